>>> hw/rtl/shbh_pkg.sv
// shared types, constants and helper functions of the sha-256 byte stream hasher
package shbh_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BLOCK_W  = 512;
    localparam int unsigned FILL_W   = 6;
    localparam int unsigned TOTAL_W  = 61;
    localparam int unsigned ROUND_W  = 6;
    localparam int unsigned IDX_W    = 3;

    // byte positions inside the 64-byte block
    localparam logic [FILL_W-1:0] FILL_BLOCK_LAST = 6'd63;
    localparam logic [FILL_W-1:0] FILL_LEN_POS    = 6'd56;
    localparam logic [FILL_W-1:0] FILL_PAD_LAST   = FILL_LEN_POS - 6'd1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // item command codes
    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // source of the byte shifted into the block buffer
    localparam logic [1:0] SEL_DATA = 2'd0;
    localparam logic [1:0] SEL_PAD  = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic             shift_en;
        logic [1:0]       shift_sel;
        logic             total_inc;
        logic             round_load;
        logic             round_en;
        logic             chain_add;
        logic             chain_init;
        logic [IDX_W-1:0] word_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              round_last;
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                 input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

>>> hw/rtl/shbh_datapath.sv
// block buffer, message schedule, round unit and chaining state
module shbh_datapath
    import shbh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [7:0]          i_data_byte,
    output t_dp_stat            o_stat,
    output logic [WORD_W-1:0]   o_digest_word
);

    logic [BLOCK_W-1:0]  r_buf;
    logic [FILL_W-1:0]   r_fill;
    logic [TOTAL_W-1:0]  r_total;
    logic [ROUND_W-1:0]  r_round;
    logic [WORD_W-1:0]   r_chain [8];
    logic [WORD_W-1:0]   r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;

    logic [7:0]          shift_byte;
    logic [63:0]         len_shifted;
    logic [WORD_W-1:0]   w0, w1, w9, w14, w_new;
    logic [WORD_W-1:0]   sum1, sum0, ch, maj, t1, t2;

    // length byte k of the big-endian bit count sits at fill 56 + k
    assign len_shifted = {r_total, 3'b000} >> {3'd7 - r_fill[2:0], 3'b000};

    always_comb begin
        case (i_cmd.shift_sel)
            SEL_DATA: shift_byte = i_data_byte;
            SEL_PAD:  shift_byte = PAD_BYTE;
            SEL_LEN:  shift_byte = len_shifted[7:0];
            default:  shift_byte = 8'h00;
        endcase
    end

    // schedule window: word j of the buffer holds w[round + j]
    assign w0  = r_buf[BLOCK_W-1      -: WORD_W];
    assign w1  = r_buf[BLOCK_W-1-32   -: WORD_W];
    assign w9  = r_buf[BLOCK_W-1-288  -: WORD_W];
    assign w14 = r_buf[BLOCK_W-1-448  -: WORD_W];
    assign w_new = w0 + (rotr32(w1, 7) ^ rotr32(w1, 18) ^ (w1 >> 3)) + w9
                 + (rotr32(w14, 17) ^ rotr32(w14, 19) ^ (w14 >> 10));

    assign sum1 = rotr32(r_e, 6) ^ rotr32(r_e, 11) ^ rotr32(r_e, 25);
    assign ch   = (r_e & r_f) ^ (~r_e & r_g);
    assign t1   = r_h + sum1 + ch + ROUND_K[r_round] + w0;
    assign sum0 = rotr32(r_a, 2) ^ rotr32(r_a, 13) ^ rotr32(r_a, 22);
    assign maj  = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
    assign t2   = sum0 + maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            r_buf <= {r_buf[BLOCK_W-9:0], shift_byte};
        end else if (i_cmd.round_en) begin
            r_buf <= {r_buf[BLOCK_W-WORD_W-1:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
            r_f <= r_chain[5];
            r_g <= r_chain[6];
            r_h <= r_chain[7];
        end else if (i_cmd.round_en) begin
            r_h <= r_g;
            r_g <= r_f;
            r_f <= r_e;
            r_e <= r_d + t1;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_a;
            r_a <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_total <= '0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= INIT_HASH[i];
            end
        end else begin
            if (i_cmd.shift_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.chain_init) begin
                r_total <= '0;
            end else if (i_cmd.total_inc) begin
                r_total <= r_total + 61'd1;
            end
            if (i_cmd.round_load) begin
                r_round <= '0;
            end else if (i_cmd.round_en) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.chain_init) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= INIT_HASH[i];
                end
            end else if (i_cmd.chain_add) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
                r_chain[5] <= r_chain[5] + r_f;
                r_chain[6] <= r_chain[6] + r_g;
                r_chain[7] <= r_chain[7] + r_h;
            end
        end
    end

    assign o_stat.fill       = r_fill;
    assign o_stat.round_last = (r_round == 6'd63);
    assign o_digest_word     = r_chain[i_cmd.word_idx];

endmodule

>>> hw/rtl/shbh_ctrl.sv
// sequencing state machine: absorb, padding, compression and digest output
module shbh_ctrl
    import shbh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_command,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LEN   = 3'd2;
    localparam logic [2:0] ST_CINIT = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_CADD  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // where to go once a compression is folded into the chain
    localparam logic [1:0] AFT_IDLE = 2'd0;
    localparam logic [1:0] AFT_PAD  = 2'd1;
    localparam logic [1:0] AFT_OUT  = 2'd2;

    localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [1:0]       r_after, n_after;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_idx       = r_idx;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.shift_en = 1'b1;
                    if (i_command == CMD_ABSORB) begin
                        o_cmd.shift_sel = SEL_DATA;
                        o_cmd.total_inc = 1'b1;
                        if (i_stat.fill == FILL_BLOCK_LAST) begin
                            n_state = ST_CINIT;
                            n_after = AFT_IDLE;
                        end
                    end else begin
                        o_cmd.shift_sel = SEL_PAD;
                        if (i_stat.fill == FILL_BLOCK_LAST) begin
                            n_state = ST_CINIT;
                            n_after = AFT_PAD;
                        end else if (i_stat.fill == FILL_PAD_LAST) begin
                            n_state = ST_LEN;
                        end else begin
                            n_state = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                o_cmd.shift_en  = 1'b1;
                o_cmd.shift_sel = SEL_ZERO;
                if (i_stat.fill == FILL_BLOCK_LAST) begin
                    n_state = ST_CINIT;
                    n_after = AFT_PAD;
                end else if (i_stat.fill == FILL_PAD_LAST) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                o_cmd.shift_en  = 1'b1;
                o_cmd.shift_sel = SEL_LEN;
                if (i_stat.fill == FILL_BLOCK_LAST) begin
                    n_state = ST_CINIT;
                    n_after = AFT_OUT;
                end
            end
            ST_CINIT: begin
                o_cmd.round_load = 1'b1;
                n_state          = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (i_stat.round_last) begin
                    n_state = ST_CADD;
                end
            end
            ST_CADD: begin
                o_cmd.chain_add = 1'b1;
                case (r_after)
                    AFT_PAD: n_state = ST_PAD;
                    AFT_OUT: begin
                        n_state = ST_OUT;
                        n_idx   = '0;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == IDX_LAST) begin
                        o_cmd.chain_init = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.word_idx = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= AFT_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_idx   <= n_idx;
        end
    end

endmodule

>>> hw/rtl/sha256_byte_stream_hasher_core.sv
// top level of the sha-256 byte stream hasher
//
//   channel  direction  handshake           payload
//   in       sink       i_valid / o_ready   i_command, i_data_byte
//   out      source     o_valid / i_ready   o_digest_word, o_word_index, o_last_word
//
// an absorb item shifts its byte into the block; the item that fills a block then starts
// a compression (load, 64 rounds, chain add) in the one-round-per-cycle compression unit.
// a finish item shifts padding and length one byte a cycle up to the block end,
// runs one or two compressions, then offers eight digest words in order.
// no item is taken while a compression runs or digest words wait; i_ready stalls
// hold the current word. reset restores the initial hash and clears counts.
module sha256_byte_stream_hasher_core
    import shbh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [7:0]         i_data_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WORD_W-1:0]  o_digest_word,
    output logic [IDX_W-1:0]   o_word_index,
    output logic               o_last_word
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    shbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_command   (i_command),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    shbh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_stat        (stat),
        .o_digest_word (o_digest_word)
    );

    assign o_word_index = cmd.word_idx;
    assign o_last_word  = (cmd.word_idx == 3'd7);

endmodule

>>> bench/sha256_byte_stream_hasher_core_test.sv
// self-checking bench for the sha-256 byte stream hasher core
import shbh_pkg::*;

typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx;
    logic              last;
} t_digest_word;

class digest_scoreboard;
    logic [31:0] k_tab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    logic [31:0] iv_tab [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]        chain [8];
    logic [7:0]         blk [64];
    int unsigned        fill;
    logic [TOTAL_W-1:0] byte_count;
    t_digest_word       digest_due [$];
    int                 errors;

    function new();
        chain = iv_tab;
        fill = 0;
        byte_count = '0;
        errors = 0;
        foreach (blk[i]) blk[i] = 8'h00;
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = chain;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endfunction

    function void note_item(logic cmd, logic [7:0] data);
        logic [63:0] bit_len;
        int unsigned pos;
        t_digest_word dw;
        if (cmd == CMD_ABSORB) begin
            blk[fill] = data;
            fill = (fill + 1) % 64;
            byte_count = byte_count + 1'b1;
            if (fill == 0)
                compress_block();
        end else begin
            bit_len = {byte_count, 3'b000};
            pos = fill;
            blk[pos] = 8'h80;
            pos++;
            // no room for the length field: pad out and run an extra block
            if (pos > 56) begin
                while (pos < 64) begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                blk[63-i] = bit_len[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                dw.word = chain[i];
                dw.idx  = IDX_W'(i);
                dw.last = (i == 7);
                digest_due = {digest_due, dw};
            end
            chain = iv_tab;
            fill = 0;
            byte_count = '0;
        end
    endfunction

    function void check_word(logic [WORD_W-1:0] word, logic [IDX_W-1:0] idx, logic last);
        t_digest_word want;
        if (digest_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected digest word %h idx %0d last %0b", word, idx, last);
        end else begin
            want = digest_due.pop_front();
            if (want.word !== word || want.idx !== idx || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display({"digest mismatch: expected %h idx %0d last %0b,",
                              " got %h idx %0d last %0b"},
                             want.word, want.idx, want.last, word, idx, last);
            end
        end
    endfunction

    function int pending();
        return digest_due.size();
    endfunction
endclass

module sha256_byte_stream_hasher_core_test;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int FLUSH_CYCLES = 200;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_command;
    logic [7:0]        i_data_byte;
    logic              o_valid;
    logic              i_ready;
    logic [WORD_W-1:0] o_digest_word;
    logic [IDX_W-1:0]  o_word_index;
    logic              o_last_word;

    digest_scoreboard board;
    int cycle_count;
    int words_seen;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    sha256_byte_stream_hasher_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_item(input logic cmd, input logic [7:0] data);
        int gap;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        board.note_item(cmd, data);
    endtask

    initial begin : stimulus
        int len;
        int sent;
        board = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_command   <= CMD_ABSORB;
        i_data_byte <= 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, then again with a data byte that must be ignored
        send_item(CMD_FINISH, 8'h00);
        send_item(CMD_FINISH, 8'hff);
        // "abc"
        send_item(CMD_ABSORB, 8'h61);
        send_item(CMD_ABSORB, 8'h62);
        send_item(CMD_ABSORB, 8'h63);
        send_item(CMD_FINISH, 8'h5a);
        send_item(CMD_ABSORB, 8'h00);
        send_item(CMD_ABSORB, 8'hff);
        send_item(CMD_ABSORB, 8'h80);
        send_item(CMD_FINISH, 8'h00);

        sent = 10;
        while (sent < 270) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(0, 12);
                // lengths around the pad/length boundary and the block end
                5, 6, 7:       len = 55 + $urandom_range(0, 1) + 8 * $urandom_range(0, 1);
                default:       len = $urandom_range(0, 130);
            endcase
            // keep the total item count close to the target
            if (sent + len > 275) len = 275 - sent;
            repeat (len) send_item(CMD_ABSORB, 8'($urandom));
            send_item(CMD_FINISH, 8'($urandom));
            sent += len + 1;
        end
        i_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : drain
        int stall;
        i_ready <= 1'b0;
        words_seen = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 12);
            // long hold-off so the core backs up and stalls its input
            if (words_seen == 24) stall = 400;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            board.check_word(o_digest_word, o_word_index, o_last_word);
            words_seen++;
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end
endmodule
